### design/fdc_pkg.sv
`default_nettype none
package fdc_pkg;
  localparam int DriveCountDef  = 16;
  localparam int SectorBytesDef = 137;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] PORT_SEL  = 2'd0;
  localparam logic [1:0] PORT_CTL  = 2'd1;
  localparam logic [1:0] PORT_DATA = 2'd2;

  localparam logic [1:0] REG_PRESENT  = 2'd0;
  localparam logic [1:0] REG_GEOMETRY = 2'd1;
  localparam logic [1:0] REG_REALTIME = 2'd2;

  localparam logic [14:0] T_SECTOR_TRUE     = 15'd5170;
  localparam logic [14:0] T_SECTOR_NOT_TRUE = 15'd30;
  localparam logic [14:0] T_STEP1           = 15'd10000;
  localparam logic [14:0] T_STEP2           = 15'd1000;
  localparam logic [14:0] T_STEP3           = 15'd20000;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] port_index;
    logic [7:0] write_value;
    logic [7:0] media_rdata;
  } fdc_in_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        irq_level;
    logic [23:0] media_addr;
    logic        media_read;
    logic        media_write;
    logic [7:0]  media_wdata;
    logic [3:0]  media_drive;
  } fdc_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the item and address the drive tables
    logic exec;   // apply the item and produce the result
  } fdc_cmd_t;

  typedef struct packed {
    logic busy;
  } fdc_stat_t;
endpackage
`default_nettype wire

### design/fdc_if.sv
`default_nettype none
interface fdc_in_if;
  logic valid;
  logic ready;
  fdc_pkg::fdc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fdc_out_if;
  logic valid;
  logic ready;
  fdc_pkg::fdc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/fdc_ctrl.sv
`default_nettype none
module fdc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fdc_pkg::fdc_cmd_t      cmd,
  input  wire fdc_pkg::fdc_stat_t stat
);
  import fdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  // A new item may enter while the previous result waits in the output register,
  // but it cannot finish until that result is taken.
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC, S_HOLD: begin
        if (!ovalid_r || out_ready) begin
          cmd.exec   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_EXEC)) else $error("load not followed by exec");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!ovalid_r || out_ready)) else $error("result overwritten");
  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy == (state_r != S_IDLE)) else $error("busy mismatch");
`endif
endmodule
`default_nettype wire

### design/fdc_dp.sv
`default_nettype none
module fdc_dp #(
  parameter int DRIVE_COUNT  = fdc_pkg::DriveCountDef,
  parameter int SECTOR_BYTES = fdc_pkg::SectorBytesDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fdc_pkg::fdc_cmd_t cmd,
  output fdc_pkg::fdc_stat_t     stat,
  input  wire fdc_pkg::fdc_in_t  in_data,
  output fdc_pkg::fdc_out_t      out_data,
  input  wire logic [15:0]       disk_present,
  input  wire logic [31:0]       geometry_codes,
  input  wire logic              realtime_mode,
  input  wire logic              rt_write,
  input  wire logic              rt_value
);
  import fdc_pkg::*;

  localparam int IW = (DRIVE_COUNT > 1) ? $clog2(DRIVE_COUNT) : 1;
  localparam logic [7:0] SB = 8'(SECTOR_BYTES);
  localparam logic [7:0] POS_RESTART = 8'hFF;

  logic [3:0]  sel_r;
  logic        selv_r;
  logic [2:0]  flags_r [DRIVE_COUNT];
  logic [10:0] track_r [DRIVE_COUNT];
  logic [4:0]  sector_r [DRIVE_COUNT];
  logic [7:0]  pos_r [DRIVE_COUNT];
  logic        st_r, tact_r, irq_r, busy_r;
  logic [1:0]  phase_r;
  logic [14:0] tcnt_r;
  fdc_in_t     item_r;
  fdc_out_t    res_r;

  // Stage one: per-drive values and the track and sector base addresses.
  logic [2:0]  c_flags_r;
  logic [10:0] c_track_r;
  logic [4:0]  c_sector_r;
  logic [7:0]  c_pos_r;
  logic [23:0] trk_base_r;
  logic [12:0] sec_base_r;
  logic [1:0]  c_geo_r;
  logic        c_disk_r;

  logic [3:0] s_idx;
  logic [1:0] geo_s;
  assign s_idx = sel_r;
  assign geo_s = geometry_codes[{s_idx, 1'b0} +: 2];
  assign stat.busy = busy_r;

  function automatic logic [11:0] ntracks(input logic [1:0] g);
    case (g)
      2'd1:    ntracks = 12'd35;
      2'd2:    ntracks = 12'd2048;
      default: ntracks = 12'd77;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r     <= in_data;
      c_flags_r  <= flags_r[s_idx[IW-1:0]];
      c_track_r  <= track_r[s_idx[IW-1:0]];
      c_sector_r <= sector_r[s_idx[IW-1:0]];
      c_pos_r    <= pos_r[s_idx[IW-1:0]];
      c_geo_r    <= geo_s;
      c_disk_r   <= disk_present[s_idx];
      trk_base_r <= 24'(32'(track_r[s_idx[IW-1:0]]) *
                    ((geo_s == 2'd1) ? 32'(16 * SECTOR_BYTES) : 32'(32 * SECTOR_BYTES)));
      sec_base_r <= 13'(32'(sector_r[s_idx[IW-1:0]]) * 32'(SECTOR_BYTES));
    end
  end

  // Stage two: apply the item.
  always_ff @(posedge clk) begin : exec_blk
    logic [3:0]  s, d;
    logic        sv, st, tact, irq, want, ste;
    logic [1:0]  ph;
    logic [14:0] tc;
    logic [2:0]  fl;
    logic [10:0] tr;
    logic [4:0]  sc, nsec;
    logic [7:0]  ps, rv;
    logic [23:0] addr;
    logic        mrd, mwr;
    logic [7:0]  mwd;
    logic [11:0] lim;
    s = sel_r; sv = selv_r; st = st_r; tact = tact_r; irq = irq_r;
    ph = phase_r; tc = tcnt_r;
    fl = c_flags_r; tr = c_track_r; sc = c_sector_r; ps = c_pos_r;
    rv = '0; addr = '0; mrd = 1'b0; mwr = 1'b0; mwd = '0; d = '0;
    nsec = (c_geo_r == 2'd1) ? 5'd15 : 5'd31;
    lim = ntracks(c_geo_r);
    ste = (ph == 2'd0) || (ph == 2'd2);
    if (!rst_n) begin
      sel_r <= '0; selv_r <= 1'b0; st_r <= 1'b0; tact_r <= 1'b0; irq_r <= 1'b0;
      phase_r <= '0; tcnt_r <= '0; busy_r <= 1'b0; res_r <= '0;
      for (int i = 0; i < DRIVE_COUNT; i++) begin
        flags_r[i] <= '0; track_r[i] <= '0; sector_r[i] <= '0; pos_r[i] <= '0;
      end
    end else begin
      if (cmd.load) busy_r <= 1'b1;
      if (rt_write) begin
        if (selv_r && !flags_r[sel_r[IW-1:0]][2]) begin
          if (rt_value) begin tact_r <= 1'b1; tcnt_r <= T_SECTOR_TRUE; end
          else begin tact_r <= 1'b0; phase_r <= '0; end
        end
      end
      if (cmd.exec) begin
        busy_r <= 1'b0;
        case (item_r.opcode)
          OP_READ: begin
            case (item_r.port_index)
              PORT_SEL: begin
                rv = 8'hFF;
                if (sv && c_disk_r) begin
                  rv = 8'h18;
                  if (ste) rv = rv | 8'h02;
                  if (fl[0]) begin
                    rv = rv | 8'h04 | (fl[1] ? 8'h01 : 8'h80);
                    if (fl[2]) rv = rv | 8'h20;
                  end
                  if (tr == '0) rv = rv | 8'h40;
                  rv = ~rv;
                end
              end
              PORT_CTL: begin
                if (sv) begin
                  if (!fl[2] && !realtime_mode) begin
                    if (st) begin st = 1'b0; rv = 8'h01; end
                    else begin
                      if (fl[1] && ps != 8'd0) begin st = 1'b0; fl[1] = 1'b0; end
                      sc = (sc >= nsec) ? 5'd0 : sc + 5'd1;
                      ps = POS_RESTART; st = 1'b1;
                    end
                  end
                  if (c_disk_r && fl[0])
                    rv = rv | 8'hC0 | {2'b00, sc, 1'b0} | {7'd0, ~st};
                end
              end
              PORT_DATA: begin
                if (sv && !fl[1]) begin
                  addr = trk_base_r + 24'(sec_base_r);
                  if (ps < SB) addr = addr + 24'(ps);
                  else ps = 8'd0;
                  mrd = 1'b1; rv = item_r.media_rdata; ps = ps + 8'd1;
                end
              end
              default: ;
            endcase
          end
          OP_WRITE: begin
            if (item_r.port_index != 2'd3) begin
              if (item_r.port_index != PORT_DATA && sv && fl[1] && ps != 8'd0) begin
                st = 1'b0; fl[1] = 1'b0; ps = POS_RESTART;
              end
              case (item_r.port_index)
                PORT_SEL: begin
                  d = item_r.write_value[3:0];
                  if (32'(d) < 32'(DRIVE_COUNT)) begin
                    tact = 1'b0; ph = '0;
                    if (item_r.write_value[7]) begin
                      if (d == s) begin
                        if (fl[1] && ps != 8'd0) st = 1'b0;
                        fl = fl & 3'b001; ps = POS_RESTART;
                      end else begin
                        if (flags_r[d[IW-1:0]][1] && pos_r[d[IW-1:0]] != 8'd0)
                          st = 1'b0;
                        flags_r[d[IW-1:0]] <= flags_r[d[IW-1:0]] & 3'b001;
                        pos_r[d[IW-1:0]] <= POS_RESTART;
                      end
                      if (sv && (fl[2] || realtime_mode))
                        begin tact = 1'b1; tc = T_SECTOR_TRUE; end
                    end else begin
                      // Drive records of the old selection are written back below; the new drive's
                      // interrupt flag comes from the table, or from the working copy if it is the old one.
                      sv = 1'b1; s = d;
                      if (((d == sel_r) ? fl[2] : flags_r[d[IW-1:0]][2]) || realtime_mode)
                        begin tact = 1'b1; tc = T_SECTOR_TRUE; end
                    end
                  end
                end
                PORT_CTL: begin
                  if (sv) begin
                    if (item_r.write_value[0] && (12'(tr) + 12'd1 < lim) && ste) begin
                      tr = tr + 11'd1; ps = POS_RESTART;
                      if (tact) begin st = 1'b0; ph = 2'd1; tc = T_STEP1; ste = 1'b0; end
                    end
                    if (item_r.write_value[1] && tr != '0 && ste) begin
                      tr = tr - 11'd1; ps = POS_RESTART;
                      if (tact) begin st = 1'b0; ph = 2'd1; tc = T_STEP1; end
                    end
                    if (item_r.write_value[2]) fl[0] = 1'b1;
                    if (item_r.write_value[3]) fl[0] = 1'b0;
                    if (item_r.write_value[4]) fl[2] = 1'b1;
                    if (item_r.write_value[5]) fl[2] = 1'b0;
                    if (item_r.write_value[7]) begin fl[1] = 1'b1; ps = 8'd0; end
                    want = fl[2] || realtime_mode;
                    if (!tact && want) begin tact = 1'b1; tc = T_SECTOR_TRUE; end
                    else if (tact && !want) begin tact = 1'b0; ph = '0; irq = 1'b0; end
                  end
                end
                PORT_DATA: begin
                  if (sv && fl[1]) begin
                    if (ps < SB) begin
                      addr = trk_base_r + 24'(sec_base_r) + 24'(ps);
                      mwr = 1'b1; mwd = item_r.write_value; ps = ps + 8'd1;
                    end else if (ps != 8'd0) begin
                      st = 1'b0; fl[1] = 1'b0; ps = POS_RESTART;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
          OP_TICK: begin
            if (tact) begin
              if (tc <= 15'd1) begin
                if (ph != 2'd0) begin
                  case (ph)
                    2'd1:    begin ph = 2'd2; tc = T_STEP2; end
                    2'd2:    begin ph = 2'd3; tc = T_STEP3; end
                    default: begin ph = 2'd0; tc = T_SECTOR_NOT_TRUE; end
                  endcase
                end else begin
                  if (st) begin st = 1'b0; tc = T_SECTOR_TRUE; end
                  else begin
                    if (sv) begin
                      if (fl[1] && ps != 8'd0) fl[1] = 1'b0;
                      sc = (sc >= nsec) ? 5'd0 : sc + 5'd1;
                      ps = POS_RESTART;
                    end
                    st = 1'b1; tc = T_SECTOR_NOT_TRUE;
                  end
                  if (sv && fl[2]) irq = st;
                end
                tact = 1'b1;
              end else tc = tc - 15'd1;
            end
          end
          default: ;
        endcase
        if (32'(sel_r) < 32'(DRIVE_COUNT)) begin
          flags_r[sel_r[IW-1:0]]  <= fl;
          track_r[sel_r[IW-1:0]]  <= tr;
          sector_r[sel_r[IW-1:0]] <= sc;
          pos_r[sel_r[IW-1:0]]    <= ps;
        end
        sel_r <= s; selv_r <= sv; st_r <= st; tact_r <= tact; irq_r <= irq;
        phase_r <= ph; tcnt_r <= tc;
        res_r.read_value  <= rv;
        res_r.irq_level   <= irq;
        res_r.media_addr  <= addr;
        res_r.media_read  <= mrd;
        res_r.media_write <= mwr;
        res_r.media_wdata <= mwd;
        res_r.media_drive <= s;
      end
    end
  end

  assign out_data = res_r;

`ifndef SYNTHESIS
  a_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_r.media_read && res_r.media_write)) else $error("both media strobes");
  a_wdata: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.exec) && !res_r.media_write |-> res_r.media_wdata == 8'd0)
    else $error("stray write data");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> tact_r || $past(rt_write)) else $error("settle without timer");
`endif
endmodule
`default_nettype wire

### design/floppy_disk_controller.sv
`default_nettype none
// Each item passes a load step, which fetches the drive record and forms the track
// and sector base addresses (two multiplies), and an execute step that applies it.
// A new item enters only after the last is applied; a waiting result stalls the next.
// Reset (rst_n low at a clock edge) clears all drive records, the timer,
// the selection and the configuration registers.
module floppy_disk_controller #(
  parameter int DRIVE_COUNT  = fdc_pkg::DriveCountDef,
  parameter int SECTOR_BYTES = fdc_pkg::SectorBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fdc_in_if.sink           in_ch,
  fdc_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import fdc_pkg::*;

  logic [15:0] present_r;
  logic [31:0] geo_r;
  logic        rt_r;
  logic        wr;
  logic [1:0]  ridx;
  fdc_cmd_t    cmd;
  fdc_stat_t   stat;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0; geo_r <= '0; rt_r <= 1'b0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_PRESENT:  present_r <= cfg_pwdata[15:0];
        REG_GEOMETRY: geo_r <= cfg_pwdata;
        REG_REALTIME: rt_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_PRESENT:  cfg_prdata = {16'd0, present_r};
      REG_GEOMETRY: cfg_prdata = geo_r;
      REG_REALTIME: cfg_prdata = {31'd0, rt_r};
      default:      cfg_prdata = '0;
    endcase
  end

  fdc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  fdc_dp #(.DRIVE_COUNT(DRIVE_COUNT), .SECTOR_BYTES(SECTOR_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_data(in_ch.data), .out_data(out_ch.data),
    .disk_present(present_r), .geometry_codes(geo_r), .realtime_mode(rt_r),
    .rt_write(wr && cfg_paddr[1:0] == 2'b00 && ridx == REG_REALTIME),
    .rt_value(cfg_pwdata[0])
  );
endmodule
`default_nettype wire

### tb/floppy_disk_controller_test.sv
`timescale 1ns / 100ps
module floppy_disk_controller_test;
  import fdc_pkg::*;

  localparam int NDRIVES = DriveCountDef;
  localparam int SBYTES  = SectorBytesDef;
  localparam logic [2:0] F_HEAD = 3'd1, F_WRITE = 3'd2, F_INTEN = 3'd4;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic     typed;
    fdc_out_t want;
  } bus_row_t;

  typedef struct {
    fdc_in_t  item;
    logic     typed;
    fdc_out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  fdc_in_if in_ch ();
  fdc_out_if out_ch ();

  floppy_disk_controller i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mirror of the controller state.
  logic [15:0] m_present;
  logic [31:0] m_geometry;
  logic        m_realtime;
  logic [3:0]  m_sel;
  logic        m_sel_ok;
  logic [2:0]  m_flags [NDRIVES];
  logic [10:0] m_track [NDRIVES];
  logic [4:0]  m_sector [NDRIVES];
  logic [7:0]  m_bytepos [NDRIVES];
  logic        m_sec_true;
  logic [1:0]  m_settle;
  logic        m_tmr_on;
  logic [14:0] m_tmr_cnt;
  logic        m_irq;

  fdc_out_t expected_results [$];
  bus_row_t offered_rows [$];
  int errors = 0;
  int idle_cycles = 0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic send_gaps = 1'b1;

  function automatic logic [1:0] geo_of(input logic [3:0] d);
    return m_geometry[2*d +: 2];
  endfunction

  function automatic int sectors_of(input logic [3:0] d);
    return (geo_of(d) == 2'd1) ? 16 : 32;
  endfunction

  function automatic int tracks_of(input logic [3:0] d);
    return (geo_of(d) == 2'd1) ? 35 : ((geo_of(d) == 2'd2) ? 2048 : 77);
  endfunction

  function automatic logic settle_allows_step();
    return m_settle == 2'd0 || m_settle == 2'd2;
  endfunction

  function automatic void end_write_mode(input logic [3:0] d);
    if ((m_flags[d] & F_WRITE) != 0 && m_bytepos[d] != 0) begin
      m_sec_true = 1'b0;
      m_flags[d] &= ~F_WRITE;
      m_bytepos[d] = 8'hFF;
    end
  endfunction

  function automatic void advance_sector(input logic [3:0] d);
    if ((m_flags[d] & F_WRITE) != 0) end_write_mode(d);
    m_sector[d] = m_sector[d] + 5'd1;
    if (int'(m_sector[d]) >= sectors_of(d)) m_sector[d] = 0;
    m_bytepos[d] = 8'hFF;
    m_sec_true = 1'b1;
  endfunction

  function automatic void arm_timer(input logic [14:0] n);
    m_tmr_on = 1'b1;
    m_tmr_cnt = n;
  endfunction

  function automatic void timer_expired();
    logic [14:0] n;
    if (m_settle != 0) begin
      if (m_settle == 2'd1) begin
        m_settle = 2'd2; n = T_STEP2;
      end else if (m_settle == 2'd2) begin
        m_settle = 2'd3; n = T_STEP3;
      end else begin
        m_settle = 2'd0; n = T_SECTOR_NOT_TRUE;
      end
    end else begin
      if (m_sec_true) begin
        m_sec_true = 1'b0;
        n = T_SECTOR_TRUE;
      end else begin
        if (m_sel_ok) advance_sector(m_sel);
        else m_sec_true = 1'b1;
        n = T_SECTOR_NOT_TRUE;
      end
      if (m_sel_ok && (m_flags[m_sel] & F_INTEN) != 0) m_irq = m_sec_true;
    end
    arm_timer(n);
  endfunction

  function automatic logic [23:0] media_addr_of(input logic [3:0] d);
    logic [31:0] a;
    a = 32'(m_track[d]) * 32'(sectors_of(d)) * SBYTES + 32'(m_sector[d]) * SBYTES
        + 32'(m_bytepos[d]);
    return a[23:0];
  endfunction

  function automatic void mirror_reset();
    m_present = '0; m_geometry = '0; m_realtime = 1'b0;
    m_sel = '0; m_sel_ok = 1'b0;
    for (int i = 0; i < NDRIVES; i++) begin
      m_flags[i] = '0; m_track[i] = '0; m_sector[i] = '0; m_bytepos[i] = '0;
    end
    m_sec_true = 1'b0; m_settle = '0; m_tmr_on = 1'b0; m_tmr_cnt = '0; m_irq = 1'b0;
  endfunction

  function automatic void mirror_config(input logic [1:0] idx, input logic [31:0] val);
    if (idx == REG_PRESENT) m_present = val[15:0];
    else if (idx == REG_GEOMETRY) m_geometry = val;
    else if (idx == REG_REALTIME) begin
      if (m_sel_ok && (m_flags[m_sel] & F_INTEN) == 0) begin
        if (val[0]) arm_timer(T_SECTOR_TRUE);
        else begin
          m_tmr_on = 1'b0; m_settle = 2'd0;
        end
      end
      m_realtime = val[0];
    end
  endfunction

  function automatic fdc_out_t bus_access_result(input fdc_in_t it);
    fdc_out_t r;
    logic [3:0] s, d;
    logic [7:0] st, v;
    logic want;
    r = '0;
    s = m_sel;
    v = it.write_value;
    if (it.opcode == OP_READ) begin
      if (it.port_index == PORT_SEL) begin
        st = '0;
        if (m_sel_ok && m_present[s]) begin
          if (settle_allows_step()) st |= 8'h02;
          if ((m_flags[s] & F_HEAD) != 0) begin
            st |= 8'h04;
            st |= ((m_flags[s] & F_WRITE) != 0) ? 8'h01 : 8'h80;
            if ((m_flags[s] & F_INTEN) != 0) st |= 8'h20;
          end
          if (m_track[s] == 0) st |= 8'h40;
          st |= 8'h18;
        end
        r.read_value = ~st;
      end else if (it.port_index == PORT_CTL) begin
        if (m_sel_ok) begin
          if ((m_flags[s] & F_INTEN) == 0 && !m_realtime) begin
            if (m_sec_true) begin
              m_sec_true = 1'b0; r.read_value |= 8'h01;
            end else advance_sector(s);
          end
          if (m_present[s] && (m_flags[s] & F_HEAD) != 0)
            r.read_value |= 8'hC0 | {2'b00, m_sector[s], 1'b0} | {7'd0, ~m_sec_true};
        end
      end else if (it.port_index == PORT_DATA) begin
        if (m_sel_ok && (m_flags[s] & F_WRITE) == 0) begin
          if (m_bytepos[s] >= SBYTES) m_bytepos[s] = 0;
          r.media_addr = media_addr_of(s);
          r.media_read = 1'b1;
          r.read_value = it.media_rdata;
          m_bytepos[s] = m_bytepos[s] + 8'd1;
        end
      end
    end else if (it.opcode == OP_WRITE && it.port_index != 2'd3) begin
      if (it.port_index != PORT_DATA && m_sel_ok && (m_flags[s] & F_WRITE) != 0)
        end_write_mode(s);
      if (it.port_index == PORT_SEL) begin
        d = v[3:0];
        m_tmr_on = 1'b0;
        m_settle = 2'd0;
        if (v[7]) begin
          end_write_mode(d);
          m_flags[d] &= F_HEAD;
          m_bytepos[d] = 8'hFF;
        end else begin
          m_sel = d; m_sel_ok = 1'b1;
        end
        s = m_sel;
        if (m_sel_ok && ((m_flags[s] & F_INTEN) != 0 || m_realtime))
          arm_timer(T_SECTOR_TRUE);
      end else if (it.port_index == PORT_CTL) begin
        if (m_sel_ok) begin
          if (v[0] && int'(m_track[s]) + 1 < tracks_of(s) && settle_allows_step()) begin
            m_track[s] = m_track[s] + 11'd1;
            m_bytepos[s] = 8'hFF;
            if (m_tmr_on) begin
              m_sec_true = 1'b0; m_settle = 2'd1; arm_timer(T_STEP1);
            end
          end
          if (v[1] && m_track[s] > 0 && settle_allows_step()) begin
            m_track[s] = m_track[s] - 11'd1;
            m_bytepos[s] = 8'hFF;
            if (m_tmr_on) begin
              m_sec_true = 1'b0; m_settle = 2'd1; arm_timer(T_STEP1);
            end
          end
          if (v[2]) m_flags[s] |= F_HEAD;
          if (v[3]) m_flags[s] &= ~F_HEAD;
          if (v[4]) m_flags[s] |= F_INTEN;
          if (v[5]) m_flags[s] &= ~F_INTEN;
          if (v[7]) begin
            m_flags[s] |= F_WRITE; m_bytepos[s] = 0;
          end
          want = (m_flags[s] & F_INTEN) != 0 || m_realtime;
          if (!m_tmr_on && want) arm_timer(T_SECTOR_TRUE);
          else if (m_tmr_on && !want) begin
            m_tmr_on = 1'b0; m_settle = 2'd0; m_irq = 1'b0;
          end
        end
      end else begin
        if (m_sel_ok && (m_flags[s] & F_WRITE) != 0) begin
          if (m_bytepos[s] < SBYTES) begin
            r.media_addr = media_addr_of(s);
            r.media_write = 1'b1;
            r.media_wdata = v;
            m_bytepos[s] = m_bytepos[s] + 8'd1;
          end else end_write_mode(s);
        end
      end
    end else if (it.opcode == OP_TICK) begin
      if (m_tmr_on) begin
        if (m_tmr_cnt <= 1) timer_expired();
        else m_tmr_cnt = m_tmr_cnt - 15'd1;
      end
    end
    r.irq_level = m_irq;
    r.media_drive = m_sel;
    return r;
  endfunction

  // Predict on accepted items, check accepted results.
  always @(posedge clk) begin
    fdc_out_t got, want;
    bus_row_t row;
    fdc_out_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value || got.irq_level !== want.irq_level ||
              got.media_addr !== want.media_addr || got.media_read !== want.media_read ||
              got.media_write !== want.media_write ||
              got.media_wdata !== want.media_wdata ||
              got.media_drive !== want.media_drive) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: rv %h/%h irq %b/%b addr %h/%h rd %b/%b wr %b/%b wd %h/%h drv %h/%h",
                       want.read_value, got.read_value, want.irq_level, got.irq_level,
                       want.media_addr, got.media_addr, want.media_read, got.media_read,
                       want.media_write, got.media_write, want.media_wdata, got.media_wdata,
                       want.media_drive, got.media_drive);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        row = offered_rows.pop_front();
        pred = bus_access_result(in_ch.data);
        expected_results.push_back(row.typed ? row.want : pred);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("floppy_disk_controller_test NOT OK");
        $finish;
      end
    end
  end

  // Receiver side.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic offer_item(input fdc_in_t it, input logic typed = 1'b0,
                            input fdc_out_t want = '0);
    offered_rows.push_back({typed, want});
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (send_gaps && !calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || offered_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    mirror_config(idx, val);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fdc_in_t mk(input logic [1:0] op, input logic [1:0] port,
                                 input logic [7:0] v = 8'h00);
    fdc_in_t it;
    it.opcode = op; it.port_index = port; it.write_value = v;
    it.media_rdata = 8'($urandom);
    return it;
  endfunction

  function automatic fdc_out_t quiet_result(input logic [7:0] rv);
    fdc_out_t r;
    r = '0;
    r.read_value = rv;
    return r;
  endfunction

  task automatic random_sequence(inout int sent);
    int kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      offer_item(mk(OP_WRITE, PORT_SEL, {$urandom_range(0, 3) == 0, 3'($urandom),
                                          4'($urandom)}));
      sent++;
    end else if (kind < 30) begin
      offer_item(mk(OP_WRITE, PORT_CTL, 8'($urandom)));
      sent++;
    end else if (kind < 45) begin
      n = $urandom_range(1, 6);
      repeat (n) offer_item(mk(OP_READ, PORT_CTL));
      offer_item(mk(OP_READ, PORT_SEL));
      sent += n + 1;
    end else if (kind < 58) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(130, 142) : $urandom_range(1, 20);
      repeat (n) offer_item(mk(OP_READ, PORT_DATA));
      sent += n;
    end else if (kind < 72) begin
      // Write a sector, sometimes past its end.
      offer_item(mk(OP_WRITE, PORT_CTL, 8'h84 | 8'($urandom_range(0, 1) << 4)));
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(135, 140) : $urandom_range(0, 12);
      repeat (n) offer_item(mk(OP_WRITE, PORT_DATA, 8'($urandom)));
      if ($urandom_range(0, 1)) offer_item(mk(OP_READ, PORT_SEL));
      sent += n + 2;
    end else if (kind < 88) begin
      n = $urandom_range(1, 40);
      repeat (n) offer_item(mk(OP_TICK, 2'($urandom), 8'($urandom)));
      sent += n;
    end else if (kind < 90) begin
      // Longer tick runs keep the timer counting down.
      n = $urandom_range(150, 400);
      repeat (n) offer_item(mk(OP_TICK, PORT_SEL));
      sent += n;
    end else begin
      offer_item(mk(2'($urandom), 2'($urandom), 8'($urandom)));
      sent++;
    end
  endtask

  stim_row_t directed [$];

  initial begin
    int sent;
    logic [31:0] presents [4];
    logic [31:0] geos [4];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    mirror_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset nothing is selected.
    directed.push_back('{mk(OP_READ, PORT_SEL), 1'b1, quiet_result(8'hFF)});
    directed.push_back('{mk(OP_READ, PORT_CTL), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_READ, PORT_DATA), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_WRITE, PORT_CTL, 8'hFF), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_WRITE, PORT_DATA, 8'hFF), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_WRITE, PORT_SEL, 8'h80), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(2'd3, PORT_SEL, 8'hFF), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_WRITE, 2'd3, 8'hFF), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_READ, 2'd3), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_TICK, PORT_SEL), 1'b1, quiet_result(8'h00)});
    directed.push_back('{mk(OP_WRITE, PORT_SEL, 8'h00), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_CTL, 8'h04), 1'b0, '0});
    directed.push_back('{mk(OP_READ, PORT_SEL), 1'b0, '0});
    directed.push_back('{mk(OP_READ, PORT_CTL), 1'b0, '0});
    directed.push_back('{mk(OP_READ, PORT_CTL), 1'b0, '0});
    directed.push_back('{mk(OP_READ, PORT_DATA), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_CTL, 8'h80), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_DATA, 8'hFF), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_DATA, 8'h00), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_SEL, 8'h8F), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_SEL, 8'h0F), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_CTL, 8'h15), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_CTL, 8'h02), 1'b0, '0});
    directed.push_back('{mk(OP_TICK, PORT_CTL), 1'b0, '0});
    directed.push_back('{mk(OP_WRITE, PORT_CTL, 8'h28), 1'b0, '0});

    write_register(REG_PRESENT, 32'h0000_FFFF);
    for (int i = 0; i < directed.size(); i++) begin
      if (i == 10) begin
        drain_results();
        write_register(REG_GEOMETRY, 32'hFFFF_FFFF);
      end
      offer_item(directed[i].item, directed[i].typed, directed[i].want);
    end

    presents = '{32'h0000_0000, 32'h0000_FFFF, 32'($urandom), 32'h0000_FFFF};
    geos = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      write_register(REG_PRESENT, (ph == 5) ? 32'($urandom) : presents[ph % 4]);
      write_register(REG_GEOMETRY, (ph == 6) ? 32'($urandom) : geos[ph % 4]);
      write_register(REG_REALTIME, 32'(ph % 2));
      if (ph == 2) hold_req = 1'b1;
      if (ph == 7) calm = 1'b1;
      while (sent < (ph + 1) * 1850 / 8) begin
        random_sequence(sent);
        if (ph == 4 && sent > 5 * 1850 / 8 - 40 && send_gaps) begin
          // Sender stops until the result side has caught up completely.
          send_gaps = 1'b0;
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (expected_results.size() != 0 || offered_rows.size() != 0) @(posedge clk);
          send_gaps = 1'b1;
        end
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("floppy_disk_controller_test OK");
    end else begin
      $display("floppy_disk_controller_test NOT OK");
    end
    $finish;
  end
endmodule

### floppy_disk_controller.f
design/fdc_pkg.sv
design/fdc_if.sv
design/fdc_ctrl.sv
design/fdc_dp.sv
design/floppy_disk_controller.sv
tb/floppy_disk_controller_test.sv
